/* design/iva_pkg.sv */
// ----------------------------------------------------------------------------
// Interrupt vector allocator package
// Shared constants, status codes and the types passed between the cells.
// ----------------------------------------------------------------------------
package iva_pkg;

   localparam int TABLE_DEPTH = 224;
   localparam int IDX_W       = 8;
   localparam int DATA_W      = 8;
   localparam int STATUS_W    = 2;

   localparam logic [DATA_W-1:0] VECTOR_BASE     = 8'd32;
   localparam logic [DATA_W-1:0] SPURIOUS_VECTOR = 8'hFF;
   localparam logic [IDX_W-1:0]  SPURIOUS_INDEX  = IDX_W'(SPURIOUS_VECTOR - VECTOR_BASE);
   localparam logic [IDX_W-1:0]  DEPTH_COUNT     = IDX_W'(TABLE_DEPTH);

   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] src;
      logic              hit;
      logic [DATA_W-1:0] vector;
      logic [DATA_W-1:0] dest;
   } token_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] src;
      logic [DATA_W-1:0] dest;
   } write_type;

endpackage

/* design/iva_cell.sv */
// ----------------------------------------------------------------------------
// Allocator table cell
// Holds one table entry and passes the lookup token to its neighbor.
// ----------------------------------------------------------------------------
module iva_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [iva_pkg::IDX_W-1:0]       cell_index,
   input  logic [iva_pkg::IDX_W-1:0]       fill_count,
   input  iva_pkg::write_type              wr,
   input  iva_pkg::token_type              token_up,
   output iva_pkg::token_type              token_down
);

   logic [iva_pkg::DATA_W-1:0] entry_src_ff;
   logic [iva_pkg::DATA_W-1:0] entry_dest_ff;
   iva_pkg::token_type         tok_ff;
   iva_pkg::token_type         tok_in;
   logic                       used;
   logic                       own_hit;

   always_comb begin
      used    = (cell_index < fill_count) && (cell_index != iva_pkg::SPURIOUS_INDEX);
      own_hit = token_up.valid && !token_up.hit && used && (entry_src_ff == token_up.src);
      tok_in  = token_up;
      if (own_hit) begin
         tok_in.hit    = 1'b1;
         tok_in.vector = iva_pkg::VECTOR_BASE + cell_index;
         tok_in.dest   = entry_dest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.index == cell_index)) begin
         entry_src_ff  <= wr.src;
         entry_dest_ff <= wr.dest;
      end
   end

   assign token_down = tok_ff;

endmodule

/* design/iva_chain.sv */
// ----------------------------------------------------------------------------
// Allocator cell chain
// Row of table cells; the lookup token walks one cell per cycle.
// ----------------------------------------------------------------------------
module iva_chain (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [iva_pkg::IDX_W-1:0]       fill_count,
   input  iva_pkg::write_type              wr,
   input  iva_pkg::token_type              token_first,
   output iva_pkg::token_type              token_last
);

   iva_pkg::token_type links [0:iva_pkg::TABLE_DEPTH];

   assign links[0] = token_first;

   for (genvar i = 0; i < iva_pkg::TABLE_DEPTH; i++) begin : g_cell
      iva_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (iva_pkg::IDX_W'(i)),
         .fill_count (fill_count),
         .wr         (wr),
         .token_up   (links[i]),
         .token_down (links[i+1])
      );
   end

   assign token_last = links[iva_pkg::TABLE_DEPTH];

endmodule

/* design/interrupt_vector_allocator_top.sv */
// ----------------------------------------------------------------------------
// Interrupt vector allocator
// Looks up an interrupt source in the allocation table and returns its
// vector, or allocates the next free vector on a miss, or reports overflow when the table is full.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Content
//  req       in         req_tvalid/tready    tdata[7:0] source_irq
//  rsp       out        rsp_tvalid/tready    tdata vector, dest_lapic; tuser status
//  csr       in         csr_wen              csr_wdata target_lapic
//
//  A request's lookup token walks the 224-cell chain one cell per cycle;
//  the result is then resolved into the pending registers in ST_SCAN and
//  loaded into the response register in ST_HOLD. The next request is
//  accepted only once the state is back in ST_IDLE after that load, so a
//  request is finished before the next is taken; a response still waiting
//  on rsp_tready holds the following request at the end of its scan. Reset
//  clears control state only; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module interrupt_vector_allocator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] source_irq
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [7:0] vector, [15:8] dest_lapic
   output logic [iva_pkg::STATUS_W-1:0]      rsp_tuser,   // [1:0] status
   input  logic                              csr_wen,
   input  logic [7:0]                        csr_wdata    // [7:0] target_lapic
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_type;

   state_type                    state_ff, state_in;
   logic [iva_pkg::IDX_W-1:0]    next_index_ff, next_index_in;
   logic [iva_pkg::DATA_W-1:0]   target_ff, target_in;
   logic [iva_pkg::DATA_W-1:0]   pend_vector_ff, pend_vector_in;
   logic [iva_pkg::DATA_W-1:0]   pend_dest_ff, pend_dest_in;
   logic [iva_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [iva_pkg::DATA_W-1:0]   rsp_vector_ff, rsp_vector_in;
   logic [iva_pkg::DATA_W-1:0]   rsp_dest_ff, rsp_dest_in;
   logic [iva_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   iva_pkg::token_type           token_first;
   iva_pkg::token_type           token_last;
   iva_pkg::write_type           wr;
   logic [iva_pkg::IDX_W-1:0]    alloc_index;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      token_first        = '0;
      token_first.valid  = req_tvalid && req_tready;
      token_first.src    = req_tdata;
   end

   iva_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .fill_count  (next_index_ff),
      .wr          (wr),
      .token_first (token_first),
      .token_last  (token_last)
   );

   always_comb begin
      state_in       = state_ff;
      next_index_in  = next_index_ff;
      target_in      = csr_wen ? csr_wdata : target_ff;
      pend_vector_in = pend_vector_ff;
      pend_dest_in   = pend_dest_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_vector_in  = rsp_vector_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_status_in  = rsp_status_ff;
      wr             = '0;
      alloc_index    = (next_index_ff == iva_pkg::SPURIOUS_INDEX) ?
                       next_index_ff + 1'b1 : next_index_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (token_last.valid) begin
               state_in = ST_HOLD;
               if (token_last.hit) begin
                  pend_vector_in = token_last.vector;
                  pend_dest_in   = token_last.dest;
                  pend_status_in = iva_pkg::STATUS_FOUND;
               end else if (alloc_index >= iva_pkg::DEPTH_COUNT) begin
                  next_index_in  = alloc_index;
                  pend_vector_in = '0;
                  pend_dest_in   = '0;
                  pend_status_in = iva_pkg::STATUS_OVERFLOW;
               end else begin
                  wr.en          = 1'b1;
                  wr.index       = alloc_index;
                  wr.src         = token_last.src;
                  wr.dest        = target_ff;
                  next_index_in  = alloc_index + 1'b1;
                  pend_vector_in = iva_pkg::VECTOR_BASE + alloc_index;
                  pend_dest_in   = target_ff;
                  pend_status_in = iva_pkg::STATUS_NEW;
               end
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_vector_in = pend_vector_ff;
               rsp_dest_in   = pend_dest_ff;
               rsp_status_in = pend_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_index_ff <= '0;
         target_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_index_ff <= next_index_in;
         target_ff     <= target_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_vector_ff <= pend_vector_in;
      pend_dest_ff   <= pend_dest_in;
      pend_status_ff <= pend_status_in;
      rsp_vector_ff  <= rsp_vector_in;
      rsp_dest_ff    <= rsp_dest_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dest_ff, rsp_vector_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* bench/tb_interrupt_vector_allocator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interrupt vector allocator testbench
// Drives source numbers into the request stream and checks every response
// against a cycle-free table model kept in a small scoreboard. The run
// starts with directed sources at the value extremes, then fills the table
// with mostly fresh sources mixed with repeats until it wraps past the
// spurious slot into overflow. The target id register is rewritten between
// phases, and both stream sides stall at varying rates.
// ----------------------------------------------------------------------------
module tb_interrupt_vector_allocator_top;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 130;
   localparam int DRAIN_CYCLES = 250;

   typedef struct {
      logic [iva_pkg::DATA_W-1:0]   vector;
      logic [iva_pkg::DATA_W-1:0]   dest;
      logic [iva_pkg::STATUS_W-1:0] status;
   } alloc_result_type;

   class vector_alloc_scoreboard_type;
      logic [iva_pkg::DATA_W-1:0] source_table [iva_pkg::TABLE_DEPTH];
      logic [iva_pkg::DATA_W-1:0] dest_table [iva_pkg::TABLE_DEPTH];
      logic [iva_pkg::IDX_W-1:0]  next_index;
      logic [iva_pkg::DATA_W-1:0] target_lapic;
      alloc_result_type           pending_results [$];
      int                         error_count;
      int                         found_count;
      int                         alloc_count;
      int                         overflow_count;

      function new();
         next_index     = '0;
         target_lapic   = '0;
         error_count    = 0;
         found_count    = 0;
         alloc_count    = 0;
         overflow_count = 0;
      endfunction

      function void set_target(logic [iva_pkg::DATA_W-1:0] value);
         target_lapic = value;
      endfunction

      function void note_request(logic [iva_pkg::DATA_W-1:0] src);
         alloc_result_type res;
         bit               hit;
         int               scan_end;
         hit        = 1'b0;
         res.vector = '0;
         res.dest   = '0;
         res.status = iva_pkg::STATUS_OVERFLOW;
         scan_end   = (next_index < iva_pkg::DEPTH_COUNT) ? int'(next_index) :
                      iva_pkg::TABLE_DEPTH;
         for (int i = 0; i < scan_end; i++) begin
            if (!hit && i != int'(iva_pkg::SPURIOUS_INDEX) && source_table[i] == src) begin
               hit        = 1'b1;
               res.vector = iva_pkg::VECTOR_BASE + i[iva_pkg::DATA_W-1:0];
               res.dest   = dest_table[i];
               res.status = iva_pkg::STATUS_FOUND;
            end
         end
         if (!hit) begin
            // skip the slot that maps to the spurious vector, even on overflow
            if (next_index == iva_pkg::SPURIOUS_INDEX)
               next_index = next_index + 1'b1;
            if (next_index < iva_pkg::DEPTH_COUNT) begin
               source_table[next_index] = src;
               dest_table[next_index]   = target_lapic;
               res.vector = iva_pkg::VECTOR_BASE + next_index;
               res.dest   = target_lapic;
               res.status = iva_pkg::STATUS_NEW;
               next_index = next_index + 1'b1;
            end
         end
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         error_count++;
      endtask

      task check_response(logic [iva_pkg::DATA_W-1:0] vector,
                          logic [iva_pkg::DATA_W-1:0] dest,
                          logic [iva_pkg::STATUS_W-1:0] status);
         alloc_result_type exp;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request pending");
         end else begin
            exp = pending_results.pop_front();
            if (vector !== exp.vector)
               report_mismatch($sformatf("vector %0h, expected %0h", vector, exp.vector));
            if (dest !== exp.dest)
               report_mismatch($sformatf("dest_lapic %0h, expected %0h", dest, exp.dest));
            if (status !== exp.status)
               report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
            case (exp.status)
               iva_pkg::STATUS_FOUND: found_count++;
               iva_pkg::STATUS_NEW:   alloc_count++;
               default:               overflow_count++;
            endcase
         end
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata = '0;   // [7:0] source_irq
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [15:0]                  rsp_tdata;        // [7:0] vector, [15:8] dest_lapic
   logic [iva_pkg::STATUS_W-1:0] rsp_tuser;        // [1:0] status
   logic                         csr_wen = 1'b0;
   logic [7:0]                   csr_wdata = '0;   // [7:0] target_lapic

   vector_alloc_scoreboard_type sb;
   int                          req_idle_pct = 0;
   int                          rsp_idle_pct = 0;
   int                          cycle_count = 0;
   int                          csr_write_count = 0;
   bit                          seen [256];
   int                          seen_count = 0;

   interrupt_vector_allocator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[7:0], rsp_tdata[15:8], rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_request(input logic [7:0] src);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= src;
      do @(posedge clock); while (!req_tready);
      sb.note_request(src);
      if (!seen[src]) begin
         seen[src] = 1'b1;
         seen_count++;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_target(input logic [7:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.set_target(value);
      csr_write_count++;
   endtask

   // bias toward fresh sources so the table fills and overflows
   function automatic logic [7:0] pick_source();
      int         roll;
      int         start;
      bit         got;
      logic [7:0] cand;
      roll  = $urandom_range(99);
      start = $urandom_range(255);
      got   = 1'b0;
      cand  = 8'($urandom_range(255));
      if (roll < 65 && seen_count < 256) begin
         for (int k = 0; k < 256 && !got; k++) begin
            if (!seen[(start + k) % 256]) begin
               cand = 8'((start + k) % 256);
               got  = 1'b1;
            end
         end
      end else if (roll < 90 && seen_count > 0) begin
         for (int k = 0; k < 256 && !got; k++) begin
            if (seen[(start + k) % 256]) begin
               cand = 8'((start + k) % 256);
               got  = 1'b1;
            end
         end
      end
      return cand;
   endfunction

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 21;
      rsp_idle_pct = 65;

      // allocate and hit with the reset target id
      send_request(8'h00);
      send_request(8'hFF);
      send_request(8'h00);
      send_request(8'hFF);
      wait_drained();
      write_target(8'hFF);
      send_request(8'h01);
      send_request(8'h80);
      send_request(8'h7F);
      send_request(8'hFE);
      send_request(8'h00);
      send_request(8'h01);
      wait_drained();
      write_target(8'h5A);
      send_request(8'hAA);
      send_request(8'h55);
      send_request(8'h80);
      send_request(8'hAA);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 21;
               rsp_idle_pct = 65;
               write_target(8'($urandom_range(1, 254)));
            end
            1: begin
               req_idle_pct = 65;
               rsp_idle_pct = 21;
               write_target(8'h00);
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               write_target(8'hFF);
            end
         endcase
         repeat (PHASE_ITEMS) send_request(pick_source());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived",
                                      sb.pending_results.size()));

      $display("Covered %0d responses: %0d hits, %0d allocations, %0d overflows",
               sb.found_count + sb.alloc_count + sb.overflow_count,
               sb.found_count, sb.alloc_count, sb.overflow_count);
      $display("Target id written %0d times, %0d distinct sources driven",
               csr_write_count, seen_count);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
